FILE: sv/sounding_level_converter_top_assert.svh
// assertion macros for the sounding level converter checker
`ifndef SOUNDING_LEVEL_CONVERTER_TOP_ASSERT_SVH
`define SOUNDING_LEVEL_CONVERTER_TOP_ASSERT_SVH

// property checked outside reset
`define SLC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sounding level converter check failed");

// property that also covers the reset cycles
`define SLC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("sounding level converter reset check failed");

`endif

FILE: sv/slc_pkg.sv
`default_nettype none

package slc_pkg;

    // default build values
    localparam int ROTATION_STEPS_DEF = 16;
    localparam int FRACTION_BITS_DEF  = 8;
    localparam int ATAN_ENTRIES       = 24;

    // field widths
    localparam int HEIGHT_W = 17;
    localparam int TEMP_W   = 18;
    localparam int DIR_W    = 17;
    localparam int SPEED_W  = 17;
    localparam int OUT_W    = 23;

    // rotation datapath widths
    localparam int XY_W   = 50;
    localparam int Z_W    = 34;
    localparam int QUAD_W = 2;

    // quadrant codes
    localparam logic [QUAD_W-1:0] QUAD_0 = 2'd0;
    localparam logic [QUAD_W-1:0] QUAD_1 = 2'd1;
    localparam logic [QUAD_W-1:0] QUAD_2 = 2'd2;
    localparam logic [QUAD_W-1:0] QUAD_3 = 2'd3;

    // output saturation
    localparam int OUT_MAX = 4194303;
    localparam int OUT_MIN = -4194304;
    localparam int SAT_W   = 34;
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(OUT_MAX);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(OUT_MIN);

    // atan(2^-i) in q30 radians
    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // rounded r * 2^fb / 10 for one leftover tenth digit
    typedef logic [9:0][15:0] t_ten_tbl;

    // fields that ride along with a level through the rotation
    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                temp_ok;
        logic [OUT_W-1:0]    temp_q;
        logic                wind_ok;
        logic [QUAD_W-1:0]   quad;
    } t_side;

    // rotation state of one level
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_rot;

    function automatic t_ten_tbl ten_table(input int fb);
        t_ten_tbl tbl;
        for (int r = 0; r < 10; r++) begin
            tbl[r] = 16'(((r << fb) + 5) / 10);
        end
        return tbl;
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return c[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/slc_prep.sv
`default_nettype none

module slc_prep #(
    parameter int FRACTION_BITS = slc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic        [slc_pkg::HEIGHT_W-1:0] i_height,
    input  wire logic signed [slc_pkg::TEMP_W-1:0]  i_temp,
    input  wire logic        [slc_pkg::DIR_W-1:0]   i_dir,
    input  wire logic        [slc_pkg::SPEED_W-1:0] i_speed,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output slc_pkg::t_side                          o_side,
    output slc_pkg::t_rot                           o_rot
);

    localparam int MISSING_MARK = 99999;
    localparam logic [16:0] TEMP_RECIP = 17'd104857;  // floor(2^20 / 10)
    localparam int TEMP_SHIFT = 20;
    localparam int TEST_W     = 14;
    localparam logic [13:0] DIR_RECIP = 14'd11650;    // floor(2^22 / 360)
    localparam int DIR_SHIFT  = 22;
    localparam int DEST_W     = 9;
    localparam logic [9:0] DEG_TURN = 10'd360;
    localparam logic [8:0] DEG_Q1   = 9'd90;
    localparam logic [8:0] DEG_Q2   = 9'd180;
    localparam logic [8:0] DEG_Q3   = 9'd270;
    localparam int REM_W = 7;
    localparam logic [29:0] GAIN_Q30       = 30'd652032874;
    localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
    localparam slc_pkg::t_ten_tbl TEN_TBL = slc_pkg::ten_table(FRACTION_BITS);

    logic rdy0, rdy1, rdy2;

    // stage 0: magnitudes and reciprocal products
    logic                        n0_tneg;
    logic [slc_pkg::TEMP_W-1:0]  n0_tmag;
    logic                        n0_temp_ok;
    logic                        n0_wind_ok;
    logic [34:0]                 n0_tprod;
    logic [30:0]                 n0_dprod;

    logic                         r0_v;
    logic [slc_pkg::HEIGHT_W-1:0] r0_height;
    logic                         r0_temp_ok;
    logic                         r0_tneg;
    logic [slc_pkg::TEMP_W-1:0]   r0_tmag;
    logic [TEST_W-1:0]            r0_test;
    logic                         r0_wind_ok;
    logic [slc_pkg::DIR_W-1:0]    r0_dir;
    logic [DEST_W-1:0]            r0_dest;
    logic [slc_pkg::SPEED_W-1:0]  r0_speed;

    // stage 1: correction, temperature result, quadrant split
    logic [slc_pkg::TEMP_W-1:0]  n1_tdiff;
    logic [4:0]                  n1_trem;
    logic                        n1_tcorr;
    logic [TEST_W-1:0]           n1_ta;
    logic [4:0]                  n1_tidx;
    logic [31:0]                 n1_tq;
    logic signed [slc_pkg::SAT_W-1:0] n1_tval;
    logic [slc_pkg::OUT_W-1:0]   n1_temp_q;
    logic [slc_pkg::DIR_W-1:0]   n1_ddiff;
    logic [9:0]                  n1_dfull;
    logic [9:0]                  n1_dmod;
    logic [8:0]                  n1_d;
    logic [slc_pkg::QUAD_W-1:0]  n1_quad;
    logic [8:0]                  n1_rem9;

    logic                         r1_v;
    slc_pkg::t_side               r1_side;
    logic [REM_W-1:0]             r1_rem;
    logic [slc_pkg::SPEED_W-1:0]  r1_speed;

    // stage 2: starting vector and angle
    logic [46:0] n2_xprod;
    logic [31:0] n2_zprod;

    logic           r2_v;
    slc_pkg::t_side r2_side;
    slc_pkg::t_rot  r2_rot;

    // stage advance chain
    assign rdy2    = !r2_v || i_ready;
    assign rdy1    = !r1_v || rdy2;
    assign rdy0    = !r0_v || rdy1;
    assign o_ready = rdy0;

    // stage 0 logic
    always_comb begin
        n0_tneg    = i_temp[slc_pkg::TEMP_W-1];
        n0_tmag    = n0_tneg ? slc_pkg::TEMP_W'(-i_temp) : slc_pkg::TEMP_W'(i_temp);
        n0_temp_ok = (i_temp != slc_pkg::TEMP_W'(MISSING_MARK));
        n0_wind_ok = (i_dir != slc_pkg::DIR_W'(MISSING_MARK))
                  && (i_speed != slc_pkg::SPEED_W'(MISSING_MARK));
        n0_tprod   = 35'(n0_tmag) * 35'(TEMP_RECIP);
        n0_dprod   = 31'(i_dir) * 31'(DIR_RECIP);
    end

    // stage 1 logic
    always_comb begin
        n1_tdiff  = r0_tmag - slc_pkg::TEMP_W'(r0_test) * slc_pkg::TEMP_W'(10);
        n1_trem   = n1_tdiff[4:0];
        n1_tcorr  = (n1_trem >= 5'd10);
        n1_ta     = r0_test + TEST_W'(n1_tcorr);
        n1_tidx   = n1_tcorr ? (n1_trem - 5'd10) : n1_trem;
        n1_tq     = (32'(n1_ta) << FRACTION_BITS) + 32'(TEN_TBL[n1_tidx[3:0]]);
        n1_tval   = r0_tneg ? -$signed(slc_pkg::SAT_W'(n1_tq))
                            : $signed(slc_pkg::SAT_W'(n1_tq));
        n1_temp_q = r0_temp_ok ? slc_pkg::sat_out(n1_tval) : '0;

        n1_ddiff  = r0_dir - slc_pkg::DIR_W'(r0_dest) * slc_pkg::DIR_W'(DEG_TURN);
        n1_dfull  = n1_ddiff[9:0];
        n1_dmod   = (n1_dfull >= DEG_TURN) ? (n1_dfull - DEG_TURN) : n1_dfull;
        n1_d      = n1_dmod[8:0];
        if (n1_d >= DEG_Q3) begin
            n1_quad = slc_pkg::QUAD_3;
            n1_rem9 = n1_d - DEG_Q3;
        end else if (n1_d >= DEG_Q2) begin
            n1_quad = slc_pkg::QUAD_2;
            n1_rem9 = n1_d - DEG_Q2;
        end else if (n1_d >= DEG_Q1) begin
            n1_quad = slc_pkg::QUAD_1;
            n1_rem9 = n1_d - DEG_Q1;
        end else begin
            n1_quad = slc_pkg::QUAD_0;
            n1_rem9 = n1_d;
        end
    end

    // stage 2 logic
    always_comb begin
        n2_xprod = 47'(r1_speed) * 47'(GAIN_Q30);
        n2_zprod = 32'(r1_rem) * 32'(DEG_TO_RAD_Q30);
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (rdy0) r0_v <= i_valid;
            if (rdy1) r1_v <= r0_v;
            if (rdy2) r2_v <= r1_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r0_height  <= i_height;
            r0_temp_ok <= n0_temp_ok;
            r0_tneg    <= n0_tneg;
            r0_tmag    <= n0_tmag;
            r0_test    <= n0_tprod[TEMP_SHIFT+TEST_W-1:TEMP_SHIFT];
            r0_wind_ok <= n0_wind_ok;
            r0_dir     <= i_dir;
            r0_dest    <= n0_dprod[DIR_SHIFT+DEST_W-1:DIR_SHIFT];
            r0_speed   <= i_speed;
        end
        if (rdy1) begin
            r1_side.height  <= r0_height;
            r1_side.temp_ok <= r0_temp_ok;
            r1_side.temp_q  <= n1_temp_q;
            r1_side.wind_ok <= r0_wind_ok;
            r1_side.quad    <= n1_quad;
            r1_rem          <= n1_rem9[REM_W-1:0];
            r1_speed        <= r0_speed;
        end
        if (rdy2) begin
            r2_side  <= r1_side;
            r2_rot.x <= $signed(slc_pkg::XY_W'(n2_xprod));
            r2_rot.y <= '0;
            r2_rot.z <= $signed(slc_pkg::Z_W'(n2_zprod));
        end
    end

    assign o_valid = r2_v;
    assign o_side  = r2_side;
    assign o_rot   = r2_rot;

endmodule

`default_nettype wire

FILE: sv/slc_cell.sv
`default_nettype none

module slc_cell #(
    parameter int IDX = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire slc_pkg::t_side i_side,
    input  wire slc_pkg::t_rot  i_rot,
    output logic                o_valid,
    input  wire logic           i_ready,
    output slc_pkg::t_side      o_side,
    output slc_pkg::t_rot       o_rot
);

    localparam logic signed [slc_pkg::Z_W-1:0] ATAN_I =
        $signed(slc_pkg::Z_W'(slc_pkg::ATAN_Q30[IDX]));

    logic                            rdy;
    logic signed [slc_pkg::XY_W-1:0] xs;
    logic signed [slc_pkg::XY_W-1:0] ys;
    logic                            z_pos;
    slc_pkg::t_rot                   n_rot;

    logic           r_v;
    slc_pkg::t_side r_side;
    slc_pkg::t_rot  r_rot;

    assign rdy = !r_v || i_ready;

    // one micro-rotation toward zero angle
    always_comb begin
        xs    = $signed(i_rot.x) >>> IDX;
        ys    = $signed(i_rot.y) >>> IDX;
        z_pos = !i_rot.z[slc_pkg::Z_W-1];
        if (z_pos) begin
            n_rot.x = i_rot.x - ys;
            n_rot.y = i_rot.y + xs;
            n_rot.z = i_rot.z - ATAN_I;
        end else begin
            n_rot.x = i_rot.x + ys;
            n_rot.y = i_rot.y - xs;
            n_rot.z = i_rot.z + ATAN_I;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid;
        end
    end

    // rotation state and side fields
    always_ff @(posedge i_clk) begin
        if (rdy) begin
            r_side <= i_side;
            r_rot  <= n_rot;
        end
    end

    assign o_ready = rdy;
    assign o_valid = r_v;
    assign o_side  = r_side;
    assign o_rot   = r_rot;

endmodule

`default_nettype wire

FILE: sv/slc_round.sv
`default_nettype none

module slc_round #(
    parameter int FRACTION_BITS = slc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire slc_pkg::t_side                     i_side,
    input  wire logic signed [slc_pkg::XY_W-1:0]    i_x,
    input  wire logic signed [slc_pkg::XY_W-1:0]    i_y,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic        [slc_pkg::HEIGHT_W-1:0]     o_height,
    output logic                                    o_temp_ok,
    output logic signed [slc_pkg::OUT_W-1:0]        o_temp_q,
    output logic                                    o_wind_ok,
    output logic signed [slc_pkg::OUT_W-1:0]        o_u,
    output logic signed [slc_pkg::OUT_W-1:0]        o_v
);

    localparam int RSH    = 30 - FRACTION_BITS;
    localparam int W_W    = 26;
    localparam int EST_W  = 23;
    localparam int MAP_W  = 25;
    localparam int LANES  = 2;
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    // anything at or above this quotient saturates anyway
    localparam int W_CLAMP = 10 * (slc_pkg::OUT_MAX + 2);
    localparam logic [26:0] RND_RECIP = 27'd107374182;  // floor(2^30 / 10)
    localparam int RND_SHIFT = 30;

    logic rdy0, rdy1, rdy2;

    // stage 0: magnitude, drop fraction, add half, clamp
    logic signed [slc_pkg::XY_W-1:0] n0_in  [LANES];
    logic                            n0_neg [LANES];
    logic [slc_pkg::XY_W-1:0]        n0_mag [LANES];
    logic [slc_pkg::XY_W-1:0]        n0_wf  [LANES];
    logic [W_W-1:0]                  n0_w   [LANES];

    logic           r0_v;
    slc_pkg::t_side r0_side;
    logic           r0_neg [LANES];
    logic [W_W-1:0] r0_w   [LANES];

    // stage 1: reciprocal multiply
    logic [52:0] n1_prod [LANES];

    logic             r1_v;
    slc_pkg::t_side   r1_side;
    logic             r1_neg [LANES];
    logic [W_W-1:0]   r1_w   [LANES];
    logic [EST_W-1:0] r1_est [LANES];

    // stage 2: quotient correction, quadrant map, saturation
    logic [W_W-1:0]               n2_rr   [LANES];
    logic [EST_W-1:0]             n2_q    [LANES];
    logic signed [MAP_W-1:0]      n2_sv   [LANES];
    logic signed [MAP_W-1:0]      n2_cs;
    logic signed [MAP_W-1:0]      n2_sn;
    logic signed [MAP_W-1:0]      n2_u;
    logic signed [MAP_W-1:0]      n2_v;
    logic [slc_pkg::OUT_W-1:0]    n2_u_out;
    logic [slc_pkg::OUT_W-1:0]    n2_v_out;

    logic                         r2_v;
    logic [slc_pkg::HEIGHT_W-1:0] r2_height;
    logic                         r2_temp_ok;
    logic [slc_pkg::OUT_W-1:0]    r2_temp_q;
    logic                         r2_wind_ok;
    logic [slc_pkg::OUT_W-1:0]    r2_u;
    logic [slc_pkg::OUT_W-1:0]    r2_v_out;

    assign rdy2    = !r2_v || i_ready;
    assign rdy1    = !r1_v || rdy2;
    assign rdy0    = !r0_v || rdy1;
    assign o_ready = rdy0;

    assign n0_in[LANE_X] = i_x;
    assign n0_in[LANE_Y] = i_y;

    // stage 0 logic
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n0_neg[l] = n0_in[l][slc_pkg::XY_W-1];
            n0_mag[l] = n0_neg[l] ? slc_pkg::XY_W'(-n0_in[l])
                                  : slc_pkg::XY_W'(n0_in[l]);
            n0_wf[l]  = (n0_mag[l] >> RSH) + slc_pkg::XY_W'(5);
            n0_w[l]   = (n0_wf[l] > slc_pkg::XY_W'(W_CLAMP)) ? W_W'(W_CLAMP)
                                                             : n0_wf[l][W_W-1:0];
        end
    end

    // stage 1 logic
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n1_prod[l] = 53'(r0_w[l]) * 53'(RND_RECIP);
        end
    end

    // stage 2 logic
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n2_rr[l] = r1_w[l] - W_W'(r1_est[l]) * W_W'(10);
            n2_q[l]  = r1_est[l] + EST_W'(n2_rr[l] >= W_W'(10));
            n2_sv[l] = r1_neg[l] ? -$signed({2'b00, n2_q[l]}) : $signed({2'b00, n2_q[l]});
        end
        n2_cs = n2_sv[LANE_X];
        n2_sn = n2_sv[LANE_Y];
        // rotate the first-quadrant result into place, u = -sin, v = -cos
        case (r1_side.quad)
            slc_pkg::QUAD_0: begin
                n2_u = -n2_sn;
                n2_v = -n2_cs;
            end
            slc_pkg::QUAD_1: begin
                n2_u = -n2_cs;
                n2_v = n2_sn;
            end
            slc_pkg::QUAD_2: begin
                n2_u = n2_sn;
                n2_v = n2_cs;
            end
            slc_pkg::QUAD_3: begin
                n2_u = n2_cs;
                n2_v = -n2_sn;
            end
            default: begin
                n2_u = n2_cs;
                n2_v = -n2_sn;
            end
        endcase
        n2_u_out = r1_side.wind_ok ? slc_pkg::sat_out(slc_pkg::SAT_W'(n2_u)) : '0;
        n2_v_out = r1_side.wind_ok ? slc_pkg::sat_out(slc_pkg::SAT_W'(n2_v)) : '0;
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (rdy0) r0_v <= i_valid;
            if (rdy1) r1_v <= r0_v;
            if (rdy2) r2_v <= r1_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r0_side <= i_side;
            for (int l = 0; l < LANES; l++) begin
                r0_neg[l] <= n0_neg[l];
                r0_w[l]   <= n0_w[l];
            end
        end
        if (rdy1) begin
            r1_side <= r0_side;
            for (int l = 0; l < LANES; l++) begin
                r1_neg[l] <= r0_neg[l];
                r1_w[l]   <= r0_w[l];
                r1_est[l] <= n1_prod[l][RND_SHIFT+EST_W-1:RND_SHIFT];
            end
        end
        if (rdy2) begin
            r2_height  <= r1_side.height;
            r2_temp_ok <= r1_side.temp_ok;
            r2_temp_q  <= r1_side.temp_q;
            r2_wind_ok <= r1_side.wind_ok;
            r2_u       <= n2_u_out;
            r2_v_out   <= n2_v_out;
        end
    end

    assign o_valid   = r2_v;
    assign o_height  = r2_height;
    assign o_temp_ok = r2_temp_ok;
    assign o_temp_q  = r2_temp_q;
    assign o_wind_ok = r2_wind_ok;
    assign o_u       = r2_u;
    assign o_v       = r2_v_out;

endmodule

`default_nettype wire

FILE: sv/sounding_level_converter_top.sv
// channel   | handshake           | payload
// ----------+---------------------+-----------------------------------------------
// level in  | i_valid / o_stall   | i_height_m, i_temp_tenths, i_dir_deg,
//           |                     | i_speed_tenths
// result    | o_valid / i_stall   | o_height_out, o_temp_ok, o_temp_deg_q8,
//           |                     | o_wind_ok, o_u_east_q8, o_v_north_q8
//
// one level per cycle while the result side does not stall; the prep stages, the chain
// of rotation cells (one cordic step per cell) and the rounding stages sit in line
// synchronous reset clears only the stage valid flags, no clearing pass
// every stage holds its own request; a held result stalls only the stages behind it
// that are full, so o_stall rises only once the whole chain is full

`default_nettype none

module sounding_level_converter_top #(
    parameter int ROTATION_STEPS = slc_pkg::ROTATION_STEPS_DEF,
    parameter int FRACTION_BITS  = slc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic        [slc_pkg::HEIGHT_W-1:0] i_height_m,
    input  wire logic signed [slc_pkg::TEMP_W-1:0]   i_temp_tenths,
    input  wire logic        [slc_pkg::DIR_W-1:0]    i_dir_deg,
    input  wire logic        [slc_pkg::SPEED_W-1:0]  i_speed_tenths,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic        [slc_pkg::HEIGHT_W-1:0]      o_height_out,
    output logic                                     o_temp_ok,
    output logic signed [slc_pkg::OUT_W-1:0]         o_temp_deg_q8,
    output logic                                     o_wind_ok,
    output logic signed [slc_pkg::OUT_W-1:0]         o_u_east_q8,
    output logic signed [slc_pkg::OUT_W-1:0]         o_v_north_q8
);

    localparam int N_STEPS = (ROTATION_STEPS < slc_pkg::ATAN_ENTRIES) ? ROTATION_STEPS
                                                                      : slc_pkg::ATAN_ENTRIES;

    logic           prep_ready;
    logic           w_v   [N_STEPS+1];
    logic           w_rdy [N_STEPS+1];
    slc_pkg::t_side w_side [N_STEPS+1];
    slc_pkg::t_rot  w_rot  [N_STEPS+1];

    // range reduction, temperature scaling, start vector
    slc_prep #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (prep_ready),
        .i_height (i_height_m),
        .i_temp   (i_temp_tenths),
        .i_dir    (i_dir_deg),
        .i_speed  (i_speed_tenths),
        .o_valid  (w_v[0]),
        .i_ready  (w_rdy[0]),
        .o_side   (w_side[0]),
        .o_rot    (w_rot[0])
    );

    // cordic rotation chain
    for (genvar k = 0; k < N_STEPS; k++) begin : g_cell
        slc_cell #(
            .IDX(k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .o_ready (w_rdy[k]),
            .i_side  (w_side[k]),
            .i_rot   (w_rot[k]),
            .o_valid (w_v[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_side  (w_side[k+1]),
            .o_rot   (w_rot[k+1])
        );
    end

    // rounding, quadrant map and output register
    slc_round #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_v[N_STEPS]),
        .o_ready   (w_rdy[N_STEPS]),
        .i_side    (w_side[N_STEPS]),
        .i_x       (w_rot[N_STEPS].x),
        .i_y       (w_rot[N_STEPS].y),
        .o_valid   (o_valid),
        .i_ready   (!i_stall),
        .o_height  (o_height_out),
        .o_temp_ok (o_temp_ok),
        .o_temp_q  (o_temp_deg_q8),
        .o_wind_ok (o_wind_ok),
        .o_u       (o_u_east_q8),
        .o_v       (o_v_north_q8)
    );

    assign o_stall = !prep_ready;

endmodule

`default_nettype wire

FILE: sv/slc_checker.sv
`default_nettype none

`include "sounding_level_converter_top_assert.svh"

module slc_assert_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_stall,
    input wire logic                                o_valid,
    input wire logic                                o_stall,
    input wire logic        [slc_pkg::HEIGHT_W-1:0] o_height_out,
    input wire logic                                o_temp_ok,
    input wire logic signed [slc_pkg::OUT_W-1:0]    o_temp_deg_q8,
    input wire logic                                o_wind_ok,
    input wire logic signed [slc_pkg::OUT_W-1:0]    o_u_east_q8,
    input wire logic signed [slc_pkg::OUT_W-1:0]    o_v_north_q8
);

    localparam int RES_W = slc_pkg::HEIGHT_W + 3 * slc_pkg::OUT_W + 2;

    logic [RES_W-1:0] res_bits;

    // result payload as one vector
    assign res_bits = {o_height_out, o_temp_ok, o_temp_deg_q8, o_wind_ok,
                       o_u_east_q8, o_v_north_q8};

    // an empty output stage means the whole chain can move
    `SLC_ASSERT(a_no_stall_when_empty, !o_valid |-> !o_stall)

    // a held result keeps its request and payload
    `SLC_ASSERT(a_hold_on_stall, o_valid && i_stall |=> o_valid && $stable(res_bits))

    // missing wind gives zero components
    `SLC_ASSERT(a_wind_missing_zero, o_valid && !o_wind_ok |-> o_u_east_q8 == '0 && o_v_north_q8 == '0)

    // reset empties the output stage
    `SLC_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_valid)

endmodule

bind sounding_level_converter_top slc_assert_checker u_slc_checker (.*);

`default_nettype wire

FILE: verif/slc_checker.sv
`timescale 1ns / 100ps

// watches both channels of the sounding level converter, predicts every result
// from the accepted level requests and compares them in order
module slc_checker #(
    parameter int ROTATION_STEPS = slc_pkg::ROTATION_STEPS_DEF,
    parameter int FRACTION_BITS  = slc_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // level channel
    input  logic                                i_lvl_valid,
    input  logic                                i_lvl_stall,
    input  logic        [slc_pkg::HEIGHT_W-1:0] i_height_m,
    input  logic signed [slc_pkg::TEMP_W-1:0]   i_temp_tenths,
    input  logic        [slc_pkg::DIR_W-1:0]    i_dir_deg,
    input  logic        [slc_pkg::SPEED_W-1:0]  i_speed_tenths,
    // result channel
    input  logic                                i_res_valid,
    input  logic                                i_res_stall,
    input  logic        [slc_pkg::HEIGHT_W-1:0] i_height_out,
    input  logic                                i_temp_ok,
    input  logic signed [slc_pkg::OUT_W-1:0]    i_temp_deg_q8,
    input  logic                                i_wind_ok,
    input  logic signed [slc_pkg::OUT_W-1:0]    i_u_east_q8,
    input  logic signed [slc_pkg::OUT_W-1:0]    i_v_north_q8,
    // totals for the testbench top
    output int                                  o_err_cnt,
    output int                                  o_pending,
    output int                                  o_res_cnt
);
    import slc_pkg::*;

    localparam longint MISSING_MARK = 99999;
    localparam longint CORDIC_GAIN  = 652032874;  // 0.60725... in q30
    localparam longint DEG_RAD      = 18740330;   // pi/180 in q30
    localparam longint SAT_MAX      = 4194303;
    localparam longint SAT_MIN      = -4194304;
    localparam int     STEP_TBL_LEN = 24;

    // atan(2^-i) in q30 radians
    localparam longint ATAN_STEP [STEP_TBL_LEN] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                temp_ok;
        logic [OUT_W-1:0]    temp_q;
        logic                wind_ok;
        logic [OUT_W-1:0]    u_east;
        logic [OUT_W-1:0]    v_north;
    } t_level_out;

    t_level_out expected_levels[$];
    int         err_cnt = 0;
    int         res_cnt = 0;

    // nearest integer of num / den, ties away from zero
    function automatic longint nearest_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // clamp to the 23-bit output range
    function automatic logic [OUT_W-1:0] clamp_out(input longint v);
        longint c;
        c = v;
        if (v > SAT_MAX) begin
            c = SAT_MAX;
        end else if (v < SAT_MIN) begin
            c = SAT_MIN;
        end
        return c[OUT_W-1:0];
    endfunction

    // converts one sounding level into the expected result
    function automatic t_level_out convert_level(
        input logic        [HEIGHT_W-1:0] height,
        input logic signed [TEMP_W-1:0]   temp,
        input logic        [DIR_W-1:0]    dir,
        input logic        [SPEED_W-1:0]  speed
    );
        t_level_out   r;
        longint       t;
        longint       x;
        longint       y;
        longint       z;
        longint       xs;
        longint       ys;
        longint       c;
        longint       s;
        longint       sn;
        longint       cs;
        longint       den;
        longint       d;
        logic [1:0]   quad;
        r = '0;
        r.height = height;

        // temperature: tenths to degrees in fixed point
        t = temp;
        r.temp_ok = (t != MISSING_MARK);
        if (r.temp_ok) begin
            r.temp_q = clamp_out(nearest_div(t * (64'sd1 <<< FRACTION_BITS), 10));
        end

        // wind: rotate the gain-scaled speed by the angle inside the quadrant
        r.wind_ok = (longint'(dir) != MISSING_MARK) && (longint'(speed) != MISSING_MARK);
        if (r.wind_ok) begin
            d    = longint'(dir) % 360;
            quad = 2'(d / 90);
            z    = (d % 90) * DEG_RAD;
            x    = longint'(speed) * CORDIC_GAIN;
            y    = 0;
            den  = 64'sd10 <<< (30 - FRACTION_BITS);
            for (int i = 0; i < ROTATION_STEPS && i < STEP_TBL_LEN; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_STEP[i];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_STEP[i];
                end
            end
            c = nearest_div(x, den);
            s = nearest_div(y, den);
            // fold the quadrant back in
            case (quad)
                slc_pkg::QUAD_0: begin
                    sn = s;
                    cs = c;
                end
                slc_pkg::QUAD_1: begin
                    sn = c;
                    cs = -s;
                end
                slc_pkg::QUAD_2: begin
                    sn = -s;
                    cs = -c;
                end
                default: begin
                    sn = -c;
                    cs = s;
                end
            endcase
            r.u_east  = clamp_out(-sn);
            r.v_north = clamp_out(-cs);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            err_cnt++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // track requests in, results out
    always @(posedge i_clk) begin
        t_level_out want;
        if (i_rst_n) begin
            if (i_lvl_valid && !i_lvl_stall) begin
                expected_levels.push_back(convert_level(i_height_m, i_temp_tenths,
                                                        i_dir_deg, i_speed_tenths));
            end
            if (i_res_valid && !i_res_stall) begin
                res_cnt++;
                if (expected_levels.size() == 0) begin
                    err_cnt++;
                    $display("%0t ns: result with no level waiting, height %0d",
                             $time, i_height_out);
                end else begin
                    want = expected_levels.pop_front();
                    check_field("height_out", want.height, i_height_out);
                    check_field("temp_ok", want.temp_ok, i_temp_ok);
                    check_field("temp_deg_q8", $signed(want.temp_q), i_temp_deg_q8);
                    check_field("wind_ok", want.wind_ok, i_wind_ok);
                    check_field("u_east_q8", $signed(want.u_east), i_u_east_q8);
                    check_field("v_north_q8", $signed(want.v_north), i_v_north_q8);
                end
            end
        end
        o_err_cnt <= err_cnt;
        o_res_cnt <= res_cnt;
        o_pending <= expected_levels.size();
    end

endmodule

FILE: verif/tb_sounding_level_converter_top.sv
`timescale 1ns / 100ps

module tb_sounding_level_converter_top;
    import slc_pkg::*;

    localparam int RANDOM_LEVELS = 1200;
    localparam int MISSING_MARK  = 99999;
    localparam int DRAIN_CYCLES  = 40;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic        [HEIGHT_W-1:0] i_height_m;
    logic signed [TEMP_W-1:0]   i_temp_tenths;
    logic        [DIR_W-1:0]    i_dir_deg;
    logic        [SPEED_W-1:0]  i_speed_tenths;
    logic                       o_valid;
    logic                       i_stall;
    logic        [HEIGHT_W-1:0] o_height_out;
    logic                       o_temp_ok;
    logic signed [OUT_W-1:0]    o_temp_deg_q8;
    logic                       o_wind_ok;
    logic signed [OUT_W-1:0]    o_u_east_q8;
    logic signed [OUT_W-1:0]    o_v_north_q8;

    int err_cnt;
    int pending;
    int res_cnt;
    int lvl_cnt      = 0;
    int no_temp_cnt  = 0;
    int no_wind_cnt  = 0;
    bit idle_en      = 1'b1;

    sounding_level_converter_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_height_m     (i_height_m),
        .i_temp_tenths  (i_temp_tenths),
        .i_dir_deg      (i_dir_deg),
        .i_speed_tenths (i_speed_tenths),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_height_out   (o_height_out),
        .o_temp_ok      (o_temp_ok),
        .o_temp_deg_q8  (o_temp_deg_q8),
        .o_wind_ok      (o_wind_ok),
        .o_u_east_q8    (o_u_east_q8),
        .o_v_north_q8   (o_v_north_q8)
    );

    slc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_lvl_valid    (i_valid),
        .i_lvl_stall    (o_stall),
        .i_height_m     (i_height_m),
        .i_temp_tenths  (i_temp_tenths),
        .i_dir_deg      (i_dir_deg),
        .i_speed_tenths (i_speed_tenths),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_height_out   (o_height_out),
        .i_temp_ok      (o_temp_ok),
        .i_temp_deg_q8  (o_temp_deg_q8),
        .i_wind_ok      (o_wind_ok),
        .i_u_east_q8    (o_u_east_q8),
        .i_v_north_q8   (o_v_north_q8),
        .o_err_cnt      (err_cnt),
        .o_pending      (pending),
        .o_res_cnt      (res_cnt)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("** sounding_level_converter_top: FAILED **");
        $finish;
    end

    // result side back-pressure
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= idle_en && ($urandom_range(99) < 6);
        end
    end

    // drive one level request and hold it until accepted; entered and left at a falling edge
    task automatic put_level(
        input logic        [HEIGHT_W-1:0] height,
        input logic signed [TEMP_W-1:0]   temp,
        input logic        [DIR_W-1:0]    dir,
        input logic        [SPEED_W-1:0]  speed
    );
        while (idle_en && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_height_m     <= height;
        i_temp_tenths  <= temp;
        i_dir_deg      <= dir;
        i_speed_tenths <= speed;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        lvl_cnt++;
        if (temp == MISSING_MARK) begin
            no_temp_cnt++;
        end
        if (dir == MISSING_MARK || speed == MISSING_MARK) begin
            no_wind_cnt++;
        end
        @(negedge i_clk);
    endtask

    // hold off new requests until every result is back
    task automatic drain_levels();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    // mostly realistic temperatures, some missing, some raw bit patterns
    function automatic logic signed [TEMP_W-1:0] pick_temp();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) begin
            return TEMP_W'(MISSING_MARK);
        end else if (sel < 20) begin
            return TEMP_W'($urandom);
        end
        return TEMP_W'(int'($urandom_range(2500)) - 2000);
    endfunction

    function automatic logic [DIR_W-1:0] pick_dir();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5) begin
            return DIR_W'(MISSING_MARK);
        end else if (sel < 15) begin
            return DIR_W'($urandom);
        end
        return DIR_W'($urandom_range(359));
    endfunction

    function automatic logic [SPEED_W-1:0] pick_speed();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5) begin
            return SPEED_W'(MISSING_MARK);
        end else if (sel < 15) begin
            return SPEED_W'($urandom);
        end
        return SPEED_W'($urandom_range(1500));
    endfunction

    // stimulus and verdict
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_height_m     = '0;
        i_temp_tenths  = '0;
        i_dir_deg      = '0;
        i_speed_tenths = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // field extremes, every quadrant and each missing reading
        put_level(0, 0, 0, 0);
        put_level(99999, -2000, 0, 100);
        put_level(131071, 99999, 90, 100);
        put_level(1, 131071, 180, 131071);
        put_level(2, -131072, 270, 99998);
        put_level(3, 1, 359, 1);
        put_level(4, -1, 360, 500);
        put_level(5, 250, 45, 200);
        put_level(6, -15, 99999, 300);
        put_level(7, 205, 135, 99999);
        put_level(8, 99999, 99999, 99999);
        put_level(9, 123, 131071, 777);
        put_level(10, -99999, 720, 65536);
        put_level(11, 99998, 225, 12345);
        put_level(12, 100000, 315, 131071);
        put_level(13, -2, 89, 131071);
        put_level(14, 7, 91, 99999 - 1);
        put_level(15, -131071, 269, 3);
        put_level(65536, 99999, 449, 1000);
        put_level(43690, -87382, 87381, 43690);
        drain_levels();

        // random levels, quiet stretch in the middle with no idling on either side
        for (int k = 0; k < RANDOM_LEVELS; k++) begin
            idle_en = !(k >= 400 && k < 700);
            if (k == 800) begin
                drain_levels();
            end
            put_level(HEIGHT_W'($urandom_range(99999)), pick_temp(), pick_dir(), pick_speed());
        end
        idle_en = 1'b1;
        i_valid <= 1'b0;

        // wait out the pipeline
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("levels sent %0d, results checked %0d, with missing temperature %0d",
                 lvl_cnt, res_cnt, no_temp_cnt);
        $display("levels with missing wind %0d, mismatches %0d", no_wind_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("** sounding_level_converter_top: PASSED **");
        end else begin
            $display("** sounding_level_converter_top: FAILED **");
        end
        $finish;
    end

endmodule
